// ===== hdl/tli_pkg.sv =====
package tli_pkg;

   // storage sizes
   localparam int PROG_DEPTH = 1024;
   localparam int TAPE_DEPTH = 2048;
   localparam int CELL_WIDTH = 32;

   localparam int PROG_AW = $clog2(PROG_DEPTH);
   localparam int PC_W    = $clog2(PROG_DEPTH + 1);
   localparam int TAPE_AW = $clog2(TAPE_DEPTH);

   // payload widths
   localparam int OP_W     = 2;
   localparam int ADDR_W   = 10;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
   localparam logic [OP_W-1:0] OP_STEP    = 2'd1;
   localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

   // run status codes
   localparam logic [STATUS_W-1:0] ST_RUN = 2'd0;
   localparam logic [STATUS_W-1:0] ST_END = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ERR = 2'd2;

   // command characters
   localparam logic [BYTE_W-1:0] CMD_END   = 8'h00;
   localparam logic [BYTE_W-1:0] CMD_RIGHT = 8'h3E;
   localparam logic [BYTE_W-1:0] CMD_LEFT  = 8'h3C;
   localparam logic [BYTE_W-1:0] CMD_INC   = 8'h2B;
   localparam logic [BYTE_W-1:0] CMD_DEC   = 8'h2D;
   localparam logic [BYTE_W-1:0] CMD_OUT   = 8'h2E;
   localparam logic [BYTE_W-1:0] CMD_OPEN  = 8'h5B;
   localparam logic [BYTE_W-1:0] CMD_CLOSE = 8'h5D;

endpackage

// ===== hdl/tli_ram.sv =====
module tli_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/tape_language_interpreter.sv =====
// channel  | direction | ports
// ---------+-----------+----------------------------------------------------
// req      | in        | req_valid req_ready req_operation req_prog_address
//          |           | req_prog_byte
// rsp      | out       | rsp_valid rsp_ready rsp_out_byte rsp_out_valid rsp_status
//
// A load, an unused operation or a step on a halted run goes from idle to the done state;
// a running step passes the exec state first, and a bracket jump walks program bytes in
// the scan state, one program store read per cycle. After reset, and on each restart, a
// clearing pass writes all TAPE_DEPTH (2048 here) tape cells to zero, one per cycle; no beat
// is accepted meanwhile and a restart's response follows the pass. One item is worked at a
// time; a finished response waits in the output register while the next item is taken.
module tape_language_interpreter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [tli_pkg::OP_W-1:0]        req_operation,
   input  logic [tli_pkg::ADDR_W-1:0]      req_prog_address,
   input  logic [tli_pkg::BYTE_W-1:0]      req_prog_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [tli_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                            rsp_out_valid,
   output logic [tli_pkg::STATUS_W-1:0]    rsp_status
);

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_EXEC  = 5'b00100,
      S_SCAN  = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [tli_pkg::PC_W-1:0]       pc_ff, pc_in;
   logic [tli_pkg::TAPE_AW-1:0]    dp_ff, dp_in;
   logic [tli_pkg::STATUS_W-1:0]   run_status_ff, run_status_in;
   logic [tli_pkg::TAPE_AW-1:0]    clr_ff, clr_in;
   logic                           clr_resp_ff, clr_resp_in;

   // bracket scan
   logic                           scan_fwd_ff, scan_fwd_in;
   logic [tli_pkg::PC_W-1:0]       rd_addr_ff, rd_addr_in;
   logic [tli_pkg::PC_W-1:0]       chk_addr_ff, chk_addr_in;
   logic                           chk_vld_ff, chk_vld_in;
   logic [tli_pkg::PC_W-1:0]       depth_ff, depth_in;

   // pending result and output register
   logic [tli_pkg::BYTE_W-1:0]     res_byte_ff, res_byte_in;
   logic                           res_flag_ff, res_flag_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [tli_pkg::BYTE_W-1:0]     rsp_out_byte_ff, rsp_out_byte_in;
   logic                           rsp_out_valid_ff, rsp_out_valid_in;
   logic [tli_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   // memory ports
   logic                              prog_we;
   logic [tli_pkg::PROG_AW-1:0]       prog_waddr;
   logic [tli_pkg::PROG_AW-1:0]       prog_raddr;
   logic [tli_pkg::BYTE_W-1:0]        prog_rdata;
   logic                              tape_we;
   logic [tli_pkg::TAPE_AW-1:0]       tape_waddr;
   logic [tli_pkg::CELL_WIDTH-1:0]    tape_wdata;
   logic [tli_pkg::CELL_WIDTH-1:0]    cell_rdata;

   logic [tli_pkg::BYTE_W-1:0]        cmd;
   logic [tli_pkg::PC_W-1:0]          pc_inc;
   logic                              scan_match;

   tli_ram #(
      .DEPTH (tli_pkg::PROG_DEPTH),
      .WIDTH (tli_pkg::BYTE_W)
   ) u_prog_ram (
      .clock (clock),
      .we    (prog_we),
      .waddr (prog_waddr),
      .wdata (req_prog_byte),
      .raddr (prog_raddr),
      .rdata (prog_rdata)
   );

   // tape is read at the data pointer every cycle; writes land before the next read
   tli_ram #(
      .DEPTH (tli_pkg::TAPE_DEPTH),
      .WIDTH (tli_pkg::CELL_WIDTH)
   ) u_tape_ram (
      .clock (clock),
      .we    (tape_we),
      .waddr (tape_waddr),
      .wdata (tape_wdata),
      .raddr (dp_ff),
      .rdata (cell_rdata)
   );

   assign prog_waddr = tli_pkg::PROG_AW'(req_prog_address);
   assign req_ready  = (state_ff == S_IDLE);
   assign pc_inc     = pc_ff + 1'b1;
   assign cmd        = (pc_ff < tli_pkg::PC_W'(tli_pkg::PROG_DEPTH)) ? prog_rdata
                                                                      : tli_pkg::CMD_END;

   always_comb begin
      state_in         = state_ff;
      pc_in            = pc_ff;
      dp_in            = dp_ff;
      run_status_in    = run_status_ff;
      clr_in           = clr_ff;
      clr_resp_in      = clr_resp_ff;
      scan_fwd_in      = scan_fwd_ff;
      rd_addr_in       = rd_addr_ff;
      chk_addr_in      = chk_addr_ff;
      chk_vld_in       = chk_vld_ff;
      depth_in         = depth_ff;
      res_byte_in      = res_byte_ff;
      res_flag_in      = res_flag_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_out_byte_in  = rsp_out_byte_ff;
      rsp_out_valid_in = rsp_out_valid_ff;
      rsp_status_in    = rsp_status_ff;
      prog_we          = 1'b0;
      prog_raddr       = pc_ff[tli_pkg::PROG_AW-1:0];
      tape_we          = 1'b0;
      tape_waddr       = dp_ff;
      tape_wdata       = '0;
      scan_match       = 1'b0;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            tape_we    = 1'b1;
            tape_waddr = clr_ff;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == tli_pkg::TAPE_AW'(tli_pkg::TAPE_DEPTH - 1)) begin
               clr_in   = '0;
               state_in = clr_resp_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               res_byte_in = '0;
               res_flag_in = 1'b0;
               state_in    = S_DONE;
               unique case (req_operation)
                  tli_pkg::OP_LOAD: begin
                     prog_we = (32'(req_prog_address) < tli_pkg::PROG_DEPTH);
                  end
                  tli_pkg::OP_STEP: begin
                     // program byte and cell come back next cycle
                     if (run_status_ff == tli_pkg::ST_RUN) begin
                        state_in = S_EXEC;
                     end
                  end
                  tli_pkg::OP_RESTART: begin
                     pc_in         = '0;
                     dp_in         = '0;
                     run_status_in = tli_pkg::ST_RUN;
                     clr_in        = '0;
                     clr_resp_in   = 1'b1;
                     state_in      = S_CLEAR;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            unique case (cmd)
               tli_pkg::CMD_END: begin
                  run_status_in = tli_pkg::ST_END;
               end
               tli_pkg::CMD_RIGHT: begin
                  dp_in = (dp_ff == tli_pkg::TAPE_AW'(tli_pkg::TAPE_DEPTH - 1)) ? '0
                                                                              : dp_ff + 1'b1;
                  pc_in = pc_inc;
               end
               tli_pkg::CMD_LEFT: begin
                  dp_in = (dp_ff == '0) ? tli_pkg::TAPE_AW'(tli_pkg::TAPE_DEPTH - 1)
                                        : dp_ff - 1'b1;
                  pc_in = pc_inc;
               end
               tli_pkg::CMD_INC: begin
                  tape_we    = 1'b1;
                  tape_wdata = cell_rdata + 1'b1;
                  pc_in      = pc_inc;
               end
               tli_pkg::CMD_DEC: begin
                  tape_we    = 1'b1;
                  tape_wdata = cell_rdata - 1'b1;
                  pc_in      = pc_inc;
               end
               tli_pkg::CMD_OUT: begin
                  res_byte_in = cell_rdata[tli_pkg::BYTE_W-1:0];
                  res_flag_in = 1'b1;
                  pc_in       = pc_inc;
               end
               tli_pkg::CMD_OPEN: begin
                  if (cell_rdata != '0) begin
                     pc_in = pc_inc;
                  end else if (pc_ff == tli_pkg::PC_W'(tli_pkg::PROG_DEPTH - 1)) begin
                     run_status_in = tli_pkg::ST_ERR;
                  end else begin
                     scan_fwd_in = 1'b1;
                     rd_addr_in  = pc_inc;
                     chk_vld_in  = 1'b0;
                     depth_in    = tli_pkg::PC_W'(1);
                     state_in    = S_SCAN;
                  end
               end
               tli_pkg::CMD_CLOSE: begin
                  if (cell_rdata == '0) begin
                     pc_in = pc_inc;
                  end else if (pc_ff == '0) begin
                     run_status_in = tli_pkg::ST_ERR;
                  end else begin
                     scan_fwd_in = 1'b0;
                     rd_addr_in  = pc_ff - 1'b1;
                     chk_vld_in  = 1'b0;
                     depth_in    = tli_pkg::PC_W'(1);
                     state_in    = S_SCAN;
                  end
               end
               default: begin
                  pc_in = pc_inc;
               end
            endcase
         end
         S_SCAN: begin
            // read one address ahead while checking the byte that just came back
            prog_raddr  = rd_addr_ff[tli_pkg::PROG_AW-1:0];
            rd_addr_in  = scan_fwd_ff ? rd_addr_ff + 1'b1 : rd_addr_ff - 1'b1;
            chk_addr_in = rd_addr_ff;
            chk_vld_in  = 1'b1;
            if (chk_vld_ff) begin
               if (scan_fwd_ff) begin
                  if (prog_rdata == tli_pkg::CMD_CLOSE) begin
                     depth_in   = depth_ff - 1'b1;
                     scan_match = (depth_ff == tli_pkg::PC_W'(1));
                  end else if (prog_rdata == tli_pkg::CMD_OPEN) begin
                     depth_in = depth_ff + 1'b1;
                  end
               end else begin
                  if (prog_rdata == tli_pkg::CMD_OPEN) begin
                     depth_in   = depth_ff - 1'b1;
                     scan_match = (depth_ff == tli_pkg::PC_W'(1));
                  end else if (prog_rdata == tli_pkg::CMD_CLOSE) begin
                     depth_in = depth_ff + 1'b1;
                  end
               end
               priority if (scan_fwd_ff && prog_rdata == tli_pkg::CMD_END) begin
                  run_status_in = tli_pkg::ST_ERR;
                  state_in      = S_DONE;
               end else if (scan_match) begin
                  pc_in    = chk_addr_ff + 1'b1;
                  state_in = S_DONE;
               end else if (scan_fwd_ff &&
                            chk_addr_ff == tli_pkg::PC_W'(tli_pkg::PROG_DEPTH - 1)) begin
                  run_status_in = tli_pkg::ST_ERR;
                  state_in      = S_DONE;
               end else if (!scan_fwd_ff && chk_addr_ff == '0) begin
                  run_status_in = tli_pkg::ST_ERR;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_out_byte_in  = res_byte_ff;
               rsp_out_valid_in = res_flag_ff;
               rsp_status_in    = run_status_ff;
               clr_resp_in      = 1'b0;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         pc_ff         <= '0;
         dp_ff         <= '0;
         run_status_ff <= tli_pkg::ST_RUN;
         clr_ff        <= '0;
         clr_resp_ff   <= 1'b0;
         chk_vld_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pc_ff         <= pc_in;
         dp_ff         <= dp_in;
         run_status_ff <= run_status_in;
         clr_ff        <= clr_in;
         clr_resp_ff   <= clr_resp_in;
         chk_vld_ff    <= chk_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_fwd_ff      <= scan_fwd_in;
      rd_addr_ff       <= rd_addr_in;
      chk_addr_ff      <= chk_addr_in;
      depth_ff         <= depth_in;
      res_byte_ff      <= res_byte_in;
      res_flag_ff      <= res_flag_in;
      rsp_out_byte_ff  <= rsp_out_byte_in;
      rsp_out_valid_ff <= rsp_out_valid_in;
      rsp_status_ff    <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_out_byte_ff;
   assign rsp_out_valid = rsp_out_valid_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

// ===== hdl/tli_checker.sv =====
module tli_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [tli_pkg::OP_W-1:0]        req_operation,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [tli_pkg::BYTE_W-1:0]      rsp_out_byte,
   input logic                            rsp_out_valid,
   input logic [tli_pkg::STATUS_W-1:0]    rsp_status
);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
         $stable(rsp_out_valid) && $stable(rsp_status))
      else $error("response beat changed while stalled");

   // only a running step emits a byte, and a silent beat carries zero
   a_emit_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_valid |-> rsp_status == tli_pkg::ST_RUN)
      else $error("output byte emitted by a halted step");

   a_silent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_valid |-> rsp_out_byte == '0)
      else $error("nonzero out byte without output flag");

   // tape clearing pass holds off requests
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("request taken before tape clear");

   a_clear_after_restart: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == tli_pkg::OP_RESTART |=> !req_ready)
      else $error("request taken during restart clear");

endmodule

bind tape_language_interpreter tli_checker u_tli_checker (.*);
